FILE: hdl/kpdd_pkg.sv
`timescale 1ns / 1ps
// kpdd_pkg: shared constants, types, key table and decrypt rule for the packet deframer
// no dependencies; imported by the top level

package kpdd_pkg;

    localparam int HEADER_BYTES = 12;

    // key table is split into even rows (keyword lookup) and odd rows (running key)
    localparam int KEY_ROWS = 256;
    localparam int KEY_AW   = $clog2(KEY_ROWS);

    // result queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    // register indexes on the config port
    localparam logic [1:0] CFG_INIT_REQUIRED = 2'd0;
    localparam logic [1:0] CFG_INIT_WORD     = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES     = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_INIT = 2'd3;

    typedef struct packed {
        logic [7:0]  msg_byte;
        logic        last_of_packet;
        logic [1:0]  status;
        logic [31:0] error_value;
    } out_item_t;

    localparam logic [7:0] KEY_TABLE [0:511] = '{
        8'h84, 8'h87, 8'h37, 8'hd7, 8'hea, 8'h79, 8'h91, 8'h7d,
        8'h4b, 8'h4b, 8'h85, 8'h7d, 8'h87, 8'h81, 8'h91, 8'h7c,
        8'h0f, 8'h73, 8'h91, 8'h91, 8'h87, 8'h7d, 8'h0d, 8'h7d,
        8'h86, 8'h8f, 8'h73, 8'h0f, 8'he1, 8'hdd, 8'h85, 8'h7d,
        8'h05, 8'h7d, 8'h85, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
        8'h0d, 8'he2, 8'h87, 8'h19, 8'h0f, 8'h79, 8'h85, 8'h86,
        8'h37, 8'h7d, 8'hd7, 8'hdd, 8'he9, 8'h7d, 8'hd7, 8'h7d,
        8'h85, 8'h79, 8'h05, 8'h7d, 8'h0f, 8'he1, 8'h87, 8'h7e,
        8'h23, 8'h87, 8'hf5, 8'h79, 8'h5f, 8'he3, 8'h4b, 8'h83,
        8'ha3, 8'ha2, 8'hae, 8'h0e, 8'h14, 8'h7d, 8'hde, 8'h7e,
        8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'ha5,
        8'h87, 8'h7d, 8'he1, 8'h7d, 8'h88, 8'h7d, 8'h15, 8'h91,
        8'h23, 8'h7d, 8'h87, 8'h7c, 8'h0d, 8'h7a, 8'h85, 8'h87,
        8'h17, 8'h7c, 8'h85, 8'h7d, 8'hac, 8'h80, 8'hbb, 8'h79,
        8'h84, 8'h9b, 8'h5b, 8'ha5, 8'hd7, 8'h8f, 8'h05, 8'h0f,
        8'h85, 8'h7e, 8'h85, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h9d,
        8'ha3, 8'h1a, 8'h0d, 8'h19, 8'h87, 8'h7c, 8'h85, 8'h7d,
        8'h84, 8'h7d, 8'h85, 8'h7e, 8'he7, 8'h97, 8'h0d, 8'h0f,
        8'h85, 8'h7b, 8'hea, 8'h7d, 8'had, 8'h80, 8'had, 8'h7d,
        8'hb7, 8'haf, 8'h0d, 8'h7d, 8'he9, 8'h3d, 8'h85, 8'h7d,
        8'h87, 8'hb7, 8'h23, 8'h7d, 8'he7, 8'hb7, 8'ha3, 8'h0c,
        8'h87, 8'h7e, 8'h85, 8'ha5, 8'h7d, 8'h76, 8'h35, 8'hb9,
        8'h0d, 8'h6f, 8'h23, 8'h7d, 8'h87, 8'h9b, 8'h85, 8'h0c,
        8'he1, 8'ha1, 8'h0d, 8'h7f, 8'h87, 8'h7d, 8'h84, 8'h7a,
        8'h84, 8'h7b, 8'he1, 8'h86, 8'he8, 8'h6f, 8'hd1, 8'h79,
        8'h85, 8'h19, 8'h53, 8'h95, 8'hc3, 8'h47, 8'h19, 8'h7d,
        8'he7, 8'h0c, 8'h37, 8'h7c, 8'h23, 8'h7d, 8'h85, 8'h7d,
        8'h4b, 8'h79, 8'h21, 8'ha5, 8'h87, 8'h7d, 8'h19, 8'h7d,
        8'h0d, 8'h7d, 8'h15, 8'h91, 8'h23, 8'h7d, 8'h87, 8'h7c,
        8'h85, 8'h7a, 8'h85, 8'haf, 8'hcd, 8'h7d, 8'h87, 8'h7d,
        8'he9, 8'h3d, 8'h85, 8'h7d, 8'h15, 8'h79, 8'h85, 8'h7d,
        8'hc1, 8'h7b, 8'hea, 8'h7d, 8'hb7, 8'h7d, 8'h85, 8'h7d,
        8'h85, 8'h7d, 8'h0d, 8'h7d, 8'he9, 8'h73, 8'h85, 8'h79,
        8'h05, 8'h7d, 8'hd7, 8'h7d, 8'h85, 8'he1, 8'hb9, 8'he1,
        8'h0f, 8'h65, 8'h85, 8'h86, 8'h2d, 8'h7d, 8'hd7, 8'hdd,
        8'ha3, 8'h8e, 8'he6, 8'h7d, 8'hde, 8'h7e, 8'hae, 8'h0e,
        8'h0f, 8'he1, 8'h89, 8'h7e, 8'h23, 8'h7d, 8'hf5, 8'h79,
        8'h23, 8'he1, 8'h4b, 8'h83, 8'h0c, 8'h0f, 8'h85, 8'h7b,
        8'h85, 8'h7e, 8'h8f, 8'h80, 8'h85, 8'h98, 8'hf5, 8'h7a,
        8'h85, 8'h1a, 8'h0d, 8'he1, 8'h0f, 8'h7c, 8'h89, 8'h0c,
        8'h85, 8'h0b, 8'h23, 8'h69, 8'h87, 8'h7b, 8'h23, 8'h0c,
        8'h1f, 8'hb7, 8'h21, 8'h7a, 8'h88, 8'h7e, 8'h8f, 8'ha5,
        8'h7d, 8'h80, 8'hb7, 8'hb9, 8'h18, 8'hbf, 8'h4b, 8'h19,
        8'h85, 8'ha5, 8'h91, 8'h80, 8'h87, 8'h81, 8'h87, 8'h7c,
        8'h0f, 8'h73, 8'h91, 8'h91, 8'h84, 8'h87, 8'h37, 8'hd7,
        8'h86, 8'h79, 8'he1, 8'hdd, 8'h85, 8'h7a, 8'h73, 8'h9b,
        8'h05, 8'h7d, 8'h0d, 8'h83, 8'h87, 8'h9c, 8'h85, 8'h33,
        8'h87, 8'h7d, 8'h85, 8'h0f, 8'h87, 8'h7d, 8'h0d, 8'h7d,
        8'hf6, 8'h7e, 8'h87, 8'h7d, 8'h88, 8'h19, 8'h89, 8'hf5,
        8'hd1, 8'hdd, 8'h85, 8'h7d, 8'h8b, 8'hc3, 8'hea, 8'h7a,
        8'hd7, 8'hb0, 8'h0d, 8'h7d, 8'h87, 8'ha5, 8'h87, 8'h7c,
        8'h73, 8'h7e, 8'h7d, 8'h86, 8'h87, 8'h23, 8'h85, 8'h10,
        8'hd7, 8'hdf, 8'hed, 8'ha5, 8'he1, 8'h7a, 8'h85, 8'h23,
        8'hea, 8'h7e, 8'h85, 8'h98, 8'had, 8'h79, 8'h86, 8'h7d,
        8'h85, 8'h7d, 8'hd7, 8'h7d, 8'he1, 8'h7a, 8'hf5, 8'h7d,
        8'h85, 8'hb0, 8'h2b, 8'h37, 8'he1, 8'h7a, 8'h87, 8'h79,
        8'h84, 8'h7d, 8'h73, 8'h73, 8'h87, 8'h7d, 8'h23, 8'h7d,
        8'he9, 8'h7d, 8'h85, 8'h7e, 8'h02, 8'h7d, 8'hdd, 8'h2d,
        8'h87, 8'h79, 8'he7, 8'h79, 8'had, 8'h7c, 8'h23, 8'hda,
        8'h87, 8'h0d, 8'h0d, 8'h7b, 8'he7, 8'h79, 8'h9b, 8'h7d,
        8'hd7, 8'h8f, 8'h05, 8'h7d, 8'h0d, 8'h34, 8'h8f, 8'h7d,
        8'had, 8'h87, 8'he9, 8'h7c, 8'h85, 8'h80, 8'h85, 8'h79,
        8'h8a, 8'hc3, 8'he7, 8'ha5, 8'he8, 8'h6b, 8'h0d, 8'h74,
        8'h10, 8'h73, 8'h33, 8'h17, 8'h0d, 8'h37, 8'h21, 8'h19
    };

    // one of four shift rules picked by the low two bits of the byte index
    function automatic logic [7:0] key_decrypt(input logic [7:0] b, input logic [7:0] k,
                                               input logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0:    r = b - {k[6:0], 1'b0};
            2'd1:    r = b + {3'b000, k[7:3]};
            2'd2:    r = b - {k[5:0], 2'b00};
            default: r = b + {5'b00000, k[7:5]};
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/kpdd_ram.sv
`timescale 1ns / 1ps
// kpdd_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module kpdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/keyed_packet_deframer_decrypter.sv
`timescale 1ns / 1ps
// keyed_packet_deframer_decrypter: init word check, size framing, key table decrypt, checksum
// depends on kpdd_pkg and kpdd_ram (two 256 x 8 key rams)
//
// a taken byte goes through one stage register, then the result queue, on its way to m_
// throughput: one byte per cycle while s_tready is high; the key ram read sits in a
// second stage, the second size byte of a good packet yields two results, drained one
// per cycle while m_tready is high
// reset: synchronous, active low; afterwards the key rams are loaded from the package
// table with s_tready low, then the block waits for an init word if one is required

module keyed_packet_deframer_decrypter (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    // received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // packet bytes and errors
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] msg_byte, [39:8] error_value
    output logic        m_tlast,   // last_of_packet
    output logic [1:0]  m_tuser    // [1:0] status
);

    import kpdd_pkg::*;

    // framing phase; the ram load runs once after reset
    typedef enum logic [2:0] {
        PH_FILL   = 3'b001,
        PH_INIT   = 3'b010,
        PH_PACKET = 3'b100
    } phase_t;

    // what the second stage does with a taken byte
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR,
        OP_PAIR,
        OP_HDR2,
        OP_HDR3,
        OP_BODY
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [7:0]  held;
        logic [1:0]  sel;
        logic        last;
        logic [1:0]  status;
        logic [31:0] err;
        logic [15:0] size;
    } s1_t;

    // config registers
    logic        init_req_reg;
    logic [31:0] init_word_reg;
    logic [15:0] max_bytes_reg;

    // framing state
    phase_t      phase_reg, phase_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] size_reg, size_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] shift_reg, shift_next;
    logic [KEY_AW-1:0] fill_addr_reg;

    // key position, taken from the even ram entry addressed by the keyword byte
    logic [7:0]  kp_reg, kp_next, kp_cur;
    logic        kp_pend_reg;
    logic [7:0]  even_rdata, odd_rdata;

    // second stage
    logic        s1_valid_reg;
    s1_t         s1_reg, s1_next;
    logic [7:0]  raw_sum_reg, raw_new;
    logic [7:0]  plain_sum_reg, plain_new;
    logic [7:0]  exp_sum_reg, exp_new;
    logic [7:0]  plain_byte;
    logic        sum_fail;

    // result queue
    out_item_t   q_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CW-1:0] count_reg;
    logic [OUT_CW:0]   committed;
    out_item_t   item0, item1;
    logic [1:0]  push_cnt;
    logic        pop;

    logic        accept;
    logic        eff_packet;
    logic [16:0] idx_plus;
    logic [15:0] size_word;
    logic        is_last;

    // key rams: even rows give the keyword position, odd rows the running key
    kpdd_ram #(.WIDTH(8), .DEPTH(KEY_ROWS)) u_even_ram (
        .aclk    (aclk),
        .wr_en   (phase_reg == PH_FILL),
        .wr_addr (fill_addr_reg),
        .wr_data (KEY_TABLE[{fill_addr_reg, 1'b0}]),
        .rd_addr (s_tdata),
        .rd_data (even_rdata)
    );

    kpdd_ram #(.WIDTH(8), .DEPTH(KEY_ROWS)) u_odd_ram (
        .aclk    (aclk),
        .wr_en   (phase_reg == PH_FILL),
        .wr_addr (fill_addr_reg),
        .wr_data (KEY_TABLE[{fill_addr_reg, 1'b1}]),
        .rd_addr (kp_cur),
        .rd_data (odd_rdata)
    );

    // room for this byte's results on top of what is queued or in flight
    assign committed = {1'b0, count_reg} + (s1_valid_reg ? (OUT_CW+1)'(2) : '0);
    assign s_tready  = (phase_reg != PH_FILL) && (committed <= (OUT_CW+1)'(OUT_DEPTH - 2));
    assign accept    = s_tvalid && s_tready;

    // the init-required bit is looked at only before the first init byte
    assign eff_packet = (phase_reg == PH_PACKET) ||
                        ((phase_reg == PH_INIT) && (idx_reg == '0) && !init_req_reg);
    assign idx_plus   = {1'b0, idx_reg} + 17'd1;
    assign size_word  = {s_tdata, held_reg};
    assign is_last    = idx_plus >= {1'b0, size_reg};
    assign kp_cur     = kp_pend_reg ? even_rdata : kp_reg;

    // first stage: framing control on the taken byte
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        size_next  = size_reg;
        held_next  = held_reg;
        shift_next = shift_reg;
        kp_next    = kp_cur;
        s1_next    = '{op: OP_NONE, data: s_tdata, held: held_reg, sel: idx_reg[1:0],
                       last: 1'b0, status: ST_OK, err: '0, size: size_reg};

        if (phase_reg == PH_FILL) begin
            if (fill_addr_reg == KEY_AW'(KEY_ROWS - 1)) begin
                phase_next = PH_INIT;
            end
        end else if (accept) begin
            if (!eff_packet) begin
                // collect the little-endian init word
                shift_next = {s_tdata, shift_reg[31:8]};
                if (idx_reg >= 16'd3) begin
                    idx_next = '0;
                    if (shift_next != init_word_reg) begin
                        s1_next.op     = OP_ERR;
                        s1_next.status = ST_BAD_INIT;
                        s1_next.err    = shift_next;
                    end else begin
                        phase_next = PH_PACKET;
                    end
                end else begin
                    idx_next = idx_plus[15:0];
                end
            end else begin
                phase_next = PH_PACKET;
                if (idx_reg == 16'd0) begin
                    held_next = s_tdata;
                    idx_next  = 16'd1;
                end else if (idx_reg == 16'd1) begin
                    if (size_word > max_bytes_reg || size_word < 16'(HEADER_BYTES)) begin
                        // drop both size bytes and resync on the next byte
                        idx_next       = '0;
                        s1_next.op     = OP_ERR;
                        s1_next.status = ST_BAD_SIZE;
                        s1_next.err    = {16'd0, size_word};
                    end else begin
                        size_next  = size_word;
                        idx_next   = 16'd2;
                        s1_next.op = OP_PAIR;
                    end
                end else begin
                    if (idx_reg == 16'd2) begin
                        s1_next.op = OP_HDR2;
                    end else if (idx_reg == 16'd3) begin
                        s1_next.op = OP_HDR3;
                    end else begin
                        s1_next.op = OP_BODY;
                        kp_next    = kp_cur + 8'd1;
                    end
                    s1_next.last = is_last;
                    idx_next     = is_last ? 16'd0 : idx_plus[15:0];
                end
            end
        end
    end

    // second stage: decrypt with the odd ram data, running sums, checksum
    always_comb begin
        raw_new    = raw_sum_reg;
        plain_new  = plain_sum_reg;
        exp_new    = exp_sum_reg;
        plain_byte = s1_reg.data;
        case (s1_reg.op)
            OP_HDR3: begin
                raw_new   = '0;
                plain_new = '0;
                exp_new   = s1_reg.data;
            end
            OP_BODY: begin
                plain_byte = key_decrypt(s1_reg.data, odd_rdata, s1_reg.sel);
                raw_new    = raw_sum_reg + s1_reg.data;
                plain_new  = plain_sum_reg + plain_byte;
            end
            default: begin
            end
        endcase
        sum_fail = s1_reg.last && ((raw_new - plain_new) != exp_new);

        item0    = '{msg_byte: plain_byte, last_of_packet: s1_reg.last,
                     status: sum_fail ? ST_CHECKSUM : ST_OK,
                     error_value: sum_fail ? {16'd0, s1_reg.size} : 32'd0};
        item1    = '{msg_byte: s1_reg.data, last_of_packet: 1'b0,
                     status: ST_OK, error_value: 32'd0};
        push_cnt = s1_valid_reg ? 2'd1 : 2'd0;
        case (s1_reg.op)
            OP_ERR: begin
                item0 = '{msg_byte: 8'd0, last_of_packet: 1'b0,
                          status: s1_reg.status, error_value: s1_reg.err};
            end
            OP_PAIR: begin
                // both size bytes go out once the size is known to be good
                item0 = '{msg_byte: s1_reg.held, last_of_packet: 1'b0,
                          status: ST_OK, error_value: 32'd0};
                push_cnt = s1_valid_reg ? 2'd2 : 2'd0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_req_reg  <= 1'b1;
            init_word_reg <= '0;
            max_bytes_reg <= 16'd8192;
            phase_reg     <= PH_FILL;
            fill_addr_reg <= '0;
            idx_reg       <= '0;
            size_reg      <= '0;
            held_reg      <= '0;
            shift_reg     <= '0;
            kp_reg        <= '0;
            kp_pend_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            raw_sum_reg   <= '0;
            plain_sum_reg <= '0;
            exp_sum_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_INIT_REQUIRED: init_req_reg  <= cfg_wr_data[0];
                    CFG_INIT_WORD:     init_word_reg <= cfg_wr_data;
                    CFG_MAX_BYTES:     max_bytes_reg <= cfg_wr_data[15:0];
                    default: begin
                    end
                endcase
            end
            phase_reg     <= phase_next;
            fill_addr_reg <= fill_addr_reg + KEY_AW'(1);
            idx_reg       <= idx_next;
            size_reg      <= size_next;
            held_reg      <= held_next;
            shift_reg     <= shift_next;
            kp_reg        <= kp_next;
            kp_pend_reg   <= accept && (s1_next.op == OP_HDR2);
            s1_valid_reg  <= accept && (s1_next.op != OP_NONE);
            if (s1_valid_reg) begin
                raw_sum_reg   <= raw_new;
                plain_sum_reg <= plain_new;
                exp_sum_reg   <= exp_new;
            end
            wr_ptr_reg <= wr_ptr_reg + OUT_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + OUT_AW'(pop);
            count_reg  <= count_reg + OUT_CW'(push_cnt) - OUT_CW'(pop);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
        if (push_cnt != 2'd0) begin
            q_mem[wr_ptr_reg] <= item0;
        end
        if (push_cnt == 2'd2) begin
            q_mem[wr_ptr_reg + OUT_AW'(1)] <= item1;
        end
    end

    // result channel
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {q_mem[rd_ptr_reg].error_value, q_mem[rd_ptr_reg].msg_byte};
    assign m_tlast  = q_mem[rd_ptr_reg].last_of_packet;
    assign m_tuser  = q_mem[rd_ptr_reg].status;

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUT_CW'(OUT_DEPTH))
        else $error("result queue overflow");

    // no byte taken while the key rams are loading
    a_no_take_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> phase_reg != PH_FILL)
        else $error("byte taken during key load");

    // a pending keyword load never meets a body byte in the same cycle
    a_kp_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        kp_pend_reg |-> !(accept && s1_next.op == OP_BODY))
        else $error("body byte right after keyword byte");

    // init word collection stays within four bytes
    a_init_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_INIT |-> idx_reg < 16'd4)
        else $error("init byte count out of range");

    // a size pair result fills two queue slots the next cycle
    a_pair_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_reg.op == OP_PAIR && !pop) |=>
            count_reg == $past(count_reg) + OUT_CW'(2))
        else $error("size pair not queued");

endmodule
